// ===== design/pfd_pkg.sv =====
`timescale 1ns / 1ps

package pfd_pkg;

  // decoder sizing
  localparam int MAX_CHANNELS = 16;
  localparam int COUNT_WIDTH  = 16;
  localparam int REG_WIDTH    = 16;
  localparam int CNT_W        = 5;
  localparam int IDX_W        = $clog2(MAX_CHANNELS);
  localparam int CMP_W        = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;
  localparam int CFG_IDX_W    = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_MIN     = 3'd0,
    CFG_PULSE_MAX     = 3'd1,
    CFG_CLAMP_LOW     = 3'd2,
    CFG_CLAMP_HIGH    = 3'd3,
    CFG_SYNC_GAP      = 3'd4,
    CFG_CHANNEL_COUNT = 3'd5
  } cfg_reg_t;

  // reset values of the configuration registers
  localparam logic [REG_WIDTH-1:0] PULSE_MIN_RST  = 16'd800;
  localparam logic [REG_WIDTH-1:0] PULSE_MAX_RST  = 16'd2200;
  localparam logic [REG_WIDTH-1:0] CLAMP_LOW_RST  = 16'd1000;
  localparam logic [REG_WIDTH-1:0] CLAMP_HIGH_RST = 16'd2000;
  localparam logic [REG_WIDTH-1:0] SYNC_GAP_RST   = 16'd2500;
  localparam logic [CNT_W-1:0]     CH_COUNT_RST   = 5'd8;

  typedef struct packed {
    logic [REG_WIDTH-1:0] pulse_min;
    logic [REG_WIDTH-1:0] pulse_max;
    logic [REG_WIDTH-1:0] clamp_low;
    logic [REG_WIDTH-1:0] clamp_high;
    logic [REG_WIDTH-1:0] sync_gap;
    logic [CNT_W-1:0]     channel_count;
  } pfd_cfg_t;

  typedef struct packed {
    logic                 channel_valid;
    logic [IDX_W-1:0]     channel_index;
    logic [REG_WIDTH-1:0] channel_value;
    logic                 frame_done;
    logic                 sync_seen;
  } pfd_res_t;

endpackage

// ===== design/pfd_core.sv =====
`timescale 1ns / 1ps

module pfd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              level,
  input  pfd_pkg::pfd_cfg_t cfg,
  output pfd_pkg::pfd_res_t res
);
  import pfd_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [IDX_W-1:0]       IDX_TOP   = IDX_W'(MAX_CHANNELS - 1);

  logic                   prev_level_r, prev_level_nxt;
  logic [COUNT_WIDTH-1:0] tick_cnt_r, tick_cnt_nxt;
  logic [IDX_W-1:0]       next_ch_r, next_ch_nxt;
  logic                   frame_end_r, frame_end_nxt;
  logic                   frame_act_r, frame_act_nxt;

  logic                   rising;
  logic [COUNT_WIDTH-1:0] interval;
  logic [CMP_W-1:0]       ival_x;
  logic                   in_window;
  logic                   is_sync;
  logic [IDX_W-1:0]       last_ch;
  logic                   active;
  logic [REG_WIDTH-1:0]   clamped;

  // edge detect and saturating interval
  assign rising   = level && !prev_level_r;
  assign interval = (tick_cnt_r == COUNT_MAX) ? COUNT_MAX : tick_cnt_r + 1'b1;
  assign ival_x   = CMP_W'(interval);

  assign in_window = (ival_x >= CMP_W'(cfg.pulse_min)) && (ival_x <= CMP_W'(cfg.pulse_max));
  assign is_sync   = ival_x > CMP_W'(cfg.sync_gap);

  // last channel index, count of zero acts as one, large counts saturate
  always_comb begin
    if (cfg.channel_count == '0) begin
      last_ch = '0;
    end else if (cfg.channel_count > CNT_W'(MAX_CHANNELS)) begin
      last_ch = IDX_TOP;
    end else begin
      last_ch = IDX_W'(cfg.channel_count - 1'b1);
    end
  end

  // clamp, low limit checked first
  always_comb begin
    if (ival_x < CMP_W'(cfg.clamp_low)) begin
      clamped = cfg.clamp_low;
    end else if (ival_x > CMP_W'(cfg.clamp_high)) begin
      clamped = cfg.clamp_high;
    end else begin
      clamped = REG_WIDTH'(interval);
    end
  end

  // an armed frame becomes active on the first in-window pulse
  assign active = frame_act_r || frame_end_r;

  // next state and result for this sample
  always_comb begin
    prev_level_nxt = level;
    tick_cnt_nxt   = interval;
    next_ch_nxt    = next_ch_r;
    frame_end_nxt  = frame_end_r;
    frame_act_nxt  = frame_act_r;
    res            = '0;
    if (rising) begin
      tick_cnt_nxt = '0;
      if (in_window) begin
        if (frame_end_r) begin
          frame_end_nxt = 1'b0;
          frame_act_nxt = 1'b1;
        end
        if (active) begin
          res.channel_valid = 1'b1;
          res.channel_index = next_ch_r;
          res.channel_value = clamped;
          if (next_ch_r >= last_ch) begin
            frame_end_nxt  = 1'b1;
            next_ch_nxt    = '0;
            res.frame_done = 1'b1;
          end else begin
            next_ch_nxt = next_ch_r + 1'b1;
          end
        end
      end else if (is_sync) begin
        next_ch_nxt   = '0;
        frame_end_nxt = 1'b1;
        frame_act_nxt = 1'b0;
        res.sync_seen = 1'b1;
      end
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      tick_cnt_r   <= '0;
      next_ch_r    <= '0;
      frame_end_r  <= 1'b0;
      frame_act_r  <= 1'b0;
    end else if (step) begin
      prev_level_r <= prev_level_nxt;
      tick_cnt_r   <= tick_cnt_nxt;
      next_ch_r    <= next_ch_nxt;
      frame_end_r  <= frame_end_nxt;
      frame_act_r  <= frame_act_nxt;
    end
  end

endmodule

// ===== design/ppm_frame_decoder_unit.sv =====
`timescale 1ns / 1ps

// channel  direction  ports
// in       input      in_valid, in_stall, in_line_level
// out      output     out_valid, out_stall, out_channel_valid, out_channel_index,
//                     out_channel_value, out_frame_done, out_sync_seen
// cfg      input      cfg_we, cfg_index, cfg_data
//
// one sample per cycle sustained while out_stall does not hold a waiting result;
// input passes the sample register and then the result register, decode logic sits between them
// rst_n is synchronous: clears decoder state, pipeline valids and config to defaults
// out_stall holds the result register; the sample register keeps taking a
// transaction as long as the result register frees up in the same cycle

module ppm_frame_decoder_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_line_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_channel_valid,
  output logic [pfd_pkg::IDX_W-1:0]     out_channel_index,
  output logic [pfd_pkg::REG_WIDTH-1:0] out_channel_value,
  output logic                          out_frame_done,
  output logic                          out_sync_seen,
  input  logic                          cfg_we,
  input  logic [pfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfd_pkg::REG_WIDTH-1:0] cfg_data
);
  import pfd_pkg::*;

  pfd_cfg_t cfg_r;
  logic     smp_valid_r;
  logic     smp_level_r;
  logic     res_valid_r;
  pfd_res_t res_r;
  pfd_res_t res_nxt;
  logic     out_free;
  logic     advance;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_min     <= PULSE_MIN_RST;
      cfg_r.pulse_max     <= PULSE_MAX_RST;
      cfg_r.clamp_low     <= CLAMP_LOW_RST;
      cfg_r.clamp_high    <= CLAMP_HIGH_RST;
      cfg_r.sync_gap      <= SYNC_GAP_RST;
      cfg_r.channel_count <= CH_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PULSE_MIN:     cfg_r.pulse_min     <= cfg_data;
        CFG_PULSE_MAX:     cfg_r.pulse_max     <= cfg_data;
        CFG_CLAMP_LOW:     cfg_r.clamp_low     <= cfg_data;
        CFG_CLAMP_HIGH:    cfg_r.clamp_high    <= cfg_data;
        CFG_SYNC_GAP:      cfg_r.sync_gap      <= cfg_data;
        CFG_CHANNEL_COUNT: cfg_r.channel_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free = !res_valid_r || !out_stall;
  assign advance  = smp_valid_r && out_free;
  assign in_stall = smp_valid_r && !out_free;

  // sample register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
    end else if (!in_stall) begin
      smp_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      smp_level_r <= in_line_level;
    end
  end

  pfd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .level (smp_level_r),
    .cfg   (cfg_r),
    .res   (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (out_free) begin
      res_valid_r <= smp_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = res_valid_r;
  assign out_channel_valid = res_r.channel_valid;
  assign out_channel_index = res_r.channel_index;
  assign out_channel_value = res_r.channel_value;
  assign out_frame_done    = res_r.frame_done;
  assign out_sync_seen     = res_r.sync_seen;

  // a tick never decodes a channel and a sync together
  a_no_chan_and_sync: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_channel_valid && out_sync_seen))
    else $error("channel and sync reported on one tick");

  // frame end only comes with a decoded channel
  a_done_needs_chan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> out_channel_valid)
    else $error("frame done without a channel");

  // empty results carry zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_channel_valid) |->
      (out_channel_index == '0 && out_channel_value == '0))
    else $error("fields set without a decoded channel");

  // the input only stalls while a result waits under a stall
  a_sample_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("sample register stuck");

endmodule
